### rtl/sem_pkg.sv
// sem_pkg: widths, codes and the multiply-accumulate schedule of the
// sampson error mean block; used by every rtl file, depends on nothing
`default_nettype none
package sem_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int COEF_W     = 21;
	localparam int ROW_W      = 3 * COEF_W;
	localparam int MEAN_W     = 20;
	localparam int SUM_W      = 32;
	localparam int AV_W       = 40;
	localparam int BV_W       = 18;
	localparam int PROD_W     = AV_W + BV_W;
	localparam int ACC_W      = 66;
	localparam int NUM_W      = 60;
	localparam int DEN_W      = 64;
	localparam int T_W        = 31;
	localparam int TL_W       = 16;
	localparam int SH_W       = 4;
	localparam int ROOT_W     = 33;
	localparam int DIV_W      = 42;
	localparam int STEP_W     = 5;
	localparam int CIDX_W     = 2;

	localparam logic [CIDX_W-1:0] CFG_ROW0 = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_ROW1 = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ROW2 = 2'd2;

	localparam logic [STEP_W-1:0] MAC_LAST   = 5'd17;
	localparam logic [STEP_W-1:0] SQR_FIRST  = 5'd18;
	localparam logic [STEP_W-1:0] SQR_DRAIN  = 5'd26;
	localparam logic [STEP_W-1:0] SQRT_LAST  = 5'd31;
	localparam logic [STEP_W-1:0] DIV_LAST   = 5'(MEAN_W - 1);

	typedef enum logic [3:0] {
		A_E00, A_E01, A_E02, A_E10, A_E11, A_E12, A_E20, A_E21, A_E22,
		A_A0, A_A1, A_A2, A_T0, A_T1, A_T2, A_T3
	} asel_t;

	typedef enum logic [2:0] {
		B_X1, B_Y1, B_X2, B_Y2, B_SIXTEEN, B_TH, B_TL
	} bsel_t;

	typedef enum logic [2:0] {
		D_NONE, D_A0, D_A1, D_A2, D_B0, D_B1, D_NUM, D_DEN
	} dest_t;

	typedef struct packed {
		asel_t a;
		bsel_t b;
		logic  clr;
		logic  shl;
		dest_t dst;
	} mac_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_MAC, OP_SHIFT, OP_CHECK, OP_SQRT,
		OP_DLOAD, OP_MLOAD, OP_DIV, OP_ACC, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic [STEP_W-1:0]  step;
	} dp_cmd_t;

	typedef struct packed {
		logic inlier;
		logic last;
		logic den_zero;
		logic count_full;
		logic count_zero;
		logic out_free;
	} dp_stat_t;

	function automatic mac_t mac_entry(input logic [STEP_W-1:0] step);
		mac_t m;
		case (step)
			5'd0:    m = '{A_E00, B_X1, 1'b1, 1'b0, D_NONE};
			5'd1:    m = '{A_E01, B_Y1, 1'b0, 1'b0, D_NONE};
			5'd2:    m = '{A_E02, B_SIXTEEN, 1'b0, 1'b0, D_A0};
			5'd3:    m = '{A_E10, B_X1, 1'b1, 1'b0, D_NONE};
			5'd4:    m = '{A_E11, B_Y1, 1'b0, 1'b0, D_NONE};
			5'd5:    m = '{A_E12, B_SIXTEEN, 1'b0, 1'b0, D_A1};
			5'd6:    m = '{A_E20, B_X1, 1'b1, 1'b0, D_NONE};
			5'd7:    m = '{A_E21, B_Y1, 1'b0, 1'b0, D_NONE};
			5'd8:    m = '{A_E22, B_SIXTEEN, 1'b0, 1'b0, D_A2};
			5'd9:    m = '{A_E00, B_X2, 1'b1, 1'b0, D_NONE};
			5'd10:   m = '{A_E10, B_Y2, 1'b0, 1'b0, D_NONE};
			5'd11:   m = '{A_E20, B_SIXTEEN, 1'b0, 1'b0, D_B0};
			5'd12:   m = '{A_E01, B_X2, 1'b1, 1'b0, D_NONE};
			5'd13:   m = '{A_E11, B_Y2, 1'b0, 1'b0, D_NONE};
			5'd14:   m = '{A_E21, B_SIXTEEN, 1'b0, 1'b0, D_B1};
			5'd15:   m = '{A_A0, B_X2, 1'b1, 1'b0, D_NONE};
			5'd16:   m = '{A_A1, B_Y2, 1'b0, 1'b0, D_NONE};
			5'd17:   m = '{A_A2, B_SIXTEEN, 1'b0, 1'b0, D_NUM};
			5'd18:   m = '{A_T0, B_TH, 1'b1, 1'b1, D_NONE};
			5'd19:   m = '{A_T0, B_TL, 1'b0, 1'b0, D_NONE};
			5'd20:   m = '{A_T1, B_TH, 1'b0, 1'b1, D_NONE};
			5'd21:   m = '{A_T1, B_TL, 1'b0, 1'b0, D_NONE};
			5'd22:   m = '{A_T2, B_TH, 1'b0, 1'b1, D_NONE};
			5'd23:   m = '{A_T2, B_TL, 1'b0, 1'b0, D_NONE};
			5'd24:   m = '{A_T3, B_TH, 1'b0, 1'b1, D_NONE};
			5'd25:   m = '{A_T3, B_TL, 1'b0, 1'b0, D_DEN};
			default: m = '{A_E00, B_X1, 1'b0, 1'b0, D_NONE};
		endcase
		return m;
	endfunction

	function automatic logic [AV_W-1:0] mag_av(input logic signed [AV_W-1:0] v);
		return v[AV_W-1] ? AV_W'(-v) : AV_W'(v);
	endfunction

endpackage
`default_nettype wire

### rtl/sem_ctrl.sv
// sem_ctrl: sequencer of the sampson error mean block
// depends on sem_pkg; drives the datapath by command, reads its status
`default_nettype none
module sem_ctrl
	import sem_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_START = 14'h0002,
		ST_MAC   = 14'h0004,
		ST_SHIFT = 14'h0008,
		ST_SQR   = 14'h0010,
		ST_CHECK = 14'h0020,
		ST_SQRT  = 14'h0040,
		ST_DLOAD = 14'h0080,
		ST_DIV   = 14'h0100,
		ST_ACC   = 14'h0200,
		ST_LAST  = 14'h0400,
		ST_MLOAD = 14'h0800,
		ST_MDIV  = 14'h1000,
		ST_OUT   = 14'h2000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		step_d   = step_q + 5'd1;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_START;
				end
			end
			ST_START: begin
				step_d  = '0;
				state_d = stat.inlier ? ST_MAC : ST_LAST;
			end
			ST_MAC: begin
				cmd.op = OP_MAC;
				if (step_q == MAC_LAST) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.op  = OP_SHIFT;
				step_d  = SQR_FIRST;
				state_d = ST_SQR;
			end
			ST_SQR: begin
				if (step_q == SQR_DRAIN) begin
					state_d = ST_CHECK;
				end else begin
					cmd.op = OP_MAC;
				end
			end
			ST_CHECK: begin
				cmd.op = OP_CHECK;
				step_d = '0;
				if (stat.den_zero || stat.count_full) begin
					state_d = ST_LAST;
				end else begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT;
				if (step_q == SQRT_LAST) state_d = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.op  = OP_DLOAD;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (step_q == DIV_LAST) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_LAST;
			end
			ST_LAST: begin
				step_d = '0;
				if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (stat.count_zero) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_MLOAD;
				end
			end
			ST_MLOAD: begin
				cmd.op  = OP_MLOAD;
				step_d  = '0;
				state_d = ST_MDIV;
			end
			ST_MDIV: begin
				cmd.op = OP_DIV;
				if (step_q == DIV_LAST) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/sem_datapath.sv
// sem_datapath: matrix registers, shared multiply-accumulate, square root,
// divider, accumulators and output register; depends on sem_pkg
`default_nettype none
module sem_datapath
	import sem_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [CIDX_W-1:0]   cfg_index,
	input  wire logic [ROW_W-1:0]    cfg_data,
	input  wire logic [COORD_W-1:0]  first_x,
	input  wire logic [COORD_W-1:0]  first_y,
	input  wire logic [COORD_W-1:0]  second_x,
	input  wire logic [COORD_W-1:0]  second_y,
	input  wire logic                inlier,
	input  wire logic                last,
	input  wire dp_cmd_t             cmd,
	output dp_stat_t                 stat,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [MEAN_W-1:0]        avg_dist,
	output logic [CNT_W-1:0]         used_count,
	output logic                     degenerate
);

	logic [ROW_W-1:0] row0_q, row1_q, row2_q;
	logic [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic inlier_q, last_q;

	logic signed [COEF_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [AV_W-1:0] a0_q, a1_q, a2_q, b0_q, b1_q;
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [SH_W-1:0] s_q;

	logic signed [AV_W-1:0] op_a;
	logic signed [BV_W-1:0] op_b;
	logic [T_W-1:0] t0, t1, t2, t3, t_sel;
	logic [AV_W-1:0] c0, c1, c2, c3, c_or;
	logic [SH_W-1:0] s_calc;
	mac_t mac;

	logic signed [PROD_W-1:0] prod_s1;
	mac_t mac_s1;
	logic valid_s1;
	logic signed [ACC_W-1:0] acc_q, acc_next, addend;

	logic [DEN_W-1:0] v_q, res_q, bitv, rsum;
	logic [DIV_W-1:0] rem_q, div_d_q, r2, dist_d, dist_hi;
	logic [MEAN_W-1:0] lo_q, q_q, quot;
	logic sat_q, ge;
	logic [NUM_W-1:0] num_mag;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0] sum_add;
	logic [CNT_W-1:0] count_q;
	logic degen_q;

	logic out_valid_q, degen_out_q;
	logic [MEAN_W-1:0] mean_q;
	logic [CNT_W-1:0] used_q;

	assign e00 = row0_q[0*COEF_W +: COEF_W];
	assign e01 = row0_q[1*COEF_W +: COEF_W];
	assign e02 = row0_q[2*COEF_W +: COEF_W];
	assign e10 = row1_q[0*COEF_W +: COEF_W];
	assign e11 = row1_q[1*COEF_W +: COEF_W];
	assign e12 = row1_q[2*COEF_W +: COEF_W];
	assign e20 = row2_q[0*COEF_W +: COEF_W];
	assign e21 = row2_q[1*COEF_W +: COEF_W];
	assign e22 = row2_q[2*COEF_W +: COEF_W];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW0: row0_q <= cfg_data;
				CFG_ROW1: row1_q <= cfg_data;
				CFG_ROW2: row2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// magnitudes and normalizing shift
	assign c0   = mag_av(a0_q);
	assign c1   = mag_av(a1_q);
	assign c2   = mag_av(b0_q);
	assign c3   = mag_av(b1_q);
	assign c_or = c0 | c1 | c2 | c3;

	always_comb begin
		s_calc = '0;
		for (int k = T_W; k < AV_W; k++) begin
			if (c_or[k]) s_calc = SH_W'(k - (T_W - 1));
		end
	end

	assign t0 = T_W'(c0 >> s_q);
	assign t1 = T_W'(c1 >> s_q);
	assign t2 = T_W'(c2 >> s_q);
	assign t3 = T_W'(c3 >> s_q);

	// multiplier operands
	assign mac = mac_entry(cmd.step);

	always_comb begin
		t_sel = '0;
		op_a  = '0;
		case (mac.a)
			A_E00:   op_a = AV_W'(e00);
			A_E01:   op_a = AV_W'(e01);
			A_E02:   op_a = AV_W'(e02);
			A_E10:   op_a = AV_W'(e10);
			A_E11:   op_a = AV_W'(e11);
			A_E12:   op_a = AV_W'(e12);
			A_E20:   op_a = AV_W'(e20);
			A_E21:   op_a = AV_W'(e21);
			A_E22:   op_a = AV_W'(e22);
			A_A0:    op_a = a0_q;
			A_A1:    op_a = a1_q;
			A_A2:    op_a = a2_q;
			A_T0:    t_sel = t0;
			A_T1:    t_sel = t1;
			A_T2:    t_sel = t2;
			A_T3:    t_sel = t3;
			default: op_a = '0;
		endcase
		if (mac.a == A_T0 || mac.a == A_T1 || mac.a == A_T2 || mac.a == A_T3) begin
			op_a = signed'({{(AV_W-T_W){1'b0}}, t_sel});
		end
	end

	always_comb begin
		case (mac.b)
			B_X1:      op_b = signed'({{(BV_W-COORD_W){1'b0}}, x1_q});
			B_Y1:      op_b = signed'({{(BV_W-COORD_W){1'b0}}, y1_q});
			B_X2:      op_b = signed'({{(BV_W-COORD_W){1'b0}}, x2_q});
			B_Y2:      op_b = signed'({{(BV_W-COORD_W){1'b0}}, y2_q});
			B_SIXTEEN: op_b = 18'sd16;
			B_TH:      op_b = signed'({{(BV_W-T_W+TL_W){1'b0}}, t_sel[T_W-1:TL_W]});
			B_TL:      op_b = signed'({{(BV_W-TL_W){1'b0}}, t_sel[TL_W-1:0]});
			default:   op_b = '0;
		endcase
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (cmd.op == OP_MAC);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		mac_s1  <= mac;
	end

	// accumulate stage
	always_comb begin
		addend   = mac_s1.shl ? (ACC_W'(prod_s1) <<< TL_W) : ACC_W'(prod_s1);
		acc_next = (mac_s1.clr ? '0 : acc_q) + addend;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= acc_next;
			case (mac_s1.dst)
				D_A0:    a0_q  <= acc_next[AV_W-1:0];
				D_A1:    a1_q  <= acc_next[AV_W-1:0];
				D_A2:    a2_q  <= acc_next[AV_W-1:0];
				D_B0:    b0_q  <= acc_next[AV_W-1:0];
				D_B1:    b1_q  <= acc_next[AV_W-1:0];
				D_NUM:   num_q <= acc_next[NUM_W-1:0];
				D_DEN:   den_q <= acc_next[DEN_W-1:0];
				default: ;
			endcase
		end
	end

	// square root and divider arithmetic
	assign bitv    = DEN_W'(1) << {~cmd.step, 1'b0};
	assign rsum    = res_q + bitv;
	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dist_d  = DIV_W'(res_q[ROOT_W-1:0]) << s_q;
	assign dist_hi = DIV_W'(num_mag >> TL_W);
	assign r2      = {rem_q[DIV_W-2:0], lo_q[MEAN_W-1]};
	assign ge      = (r2 >= div_d_q);
	assign quot    = sat_q ? '1 : q_q;
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(quot);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x1_q     <= first_x;
				y1_q     <= first_y;
				x2_q     <= second_x;
				y2_q     <= second_y;
				inlier_q <= inlier;
				last_q   <= last;
			end
			OP_SHIFT: begin
				s_q <= s_calc;
			end
			OP_CHECK: begin
				v_q   <= den_q;
				res_q <= '0;
			end
			OP_SQRT: begin
				if (v_q >= rsum) begin
					v_q   <= v_q - rsum;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			OP_DLOAD: begin
				div_d_q <= dist_d;
				rem_q   <= dist_hi;
				sat_q   <= (dist_hi >= dist_d);
				lo_q    <= {num_mag[TL_W-1:0], 4'b0000};
				q_q     <= '0;
			end
			OP_MLOAD: begin
				div_d_q <= DIV_W'(count_q);
				rem_q   <= DIV_W'(sum_q[SUM_W-1:MEAN_W]);
				sat_q   <= (DIV_W'(sum_q[SUM_W-1:MEAN_W]) >= DIV_W'(count_q));
				lo_q    <= sum_q[MEAN_W-1:0];
				q_q     <= '0;
			end
			OP_DIV: begin
				rem_q <= ge ? (r2 - div_d_q) : r2;
				q_q   <= {q_q[MEAN_W-2:0], ge};
				lo_q  <= lo_q << 1;
			end
			default: ;
		endcase
	end

	// accumulators and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && cmd.op != OP_OUT) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_CHECK: begin
					if (den_q == '0) degen_q <= 1'b1;
				end
				OP_ACC: begin
					sum_q   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
					count_q <= count_q + 1'b1;
				end
				OP_OUT: begin
					out_valid_q <= 1'b1;
					sum_q       <= '0;
					count_q     <= '0;
					degen_q     <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			mean_q      <= (count_q == '0) ? '0 : quot;
			used_q      <= count_q;
			degen_out_q <= degen_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign avg_dist   = mean_q;
	assign used_count = used_q;
	assign degenerate = degen_out_q;

	assign stat.inlier     = inlier_q;
	assign stat.last       = last_q;
	assign stat.den_zero   = (den_q == '0);
	assign stat.count_full = (count_q >= CNT_W'(MAX_POINTS));
	assign stat.count_zero = (count_q == '0);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

### rtl/sampson_error_mean.sv
// sampson_error_mean: top level, sequencer plus datapath
// depends on sem_pkg, sem_ctrl, sem_datapath
//
//   channel  direction  handshake              beat
//   in       sink       in_valid / in_stall    first_x first_y second_x second_y inlier last
//   out      source     out_valid / out_stall  avg_dist used_count degenerate
//   cfg      sink       cfg_valid / cfg_ready  cfg_index cfg_data
//
// an outlier or non-final skipped beat passes only the start and last states; an inlier used in the mean goes through
// 18 issue slots of one shared 40x18 multiplier, the squares on the same multiplier, 32 square
// root steps and 20 divider steps
// a last beat adds the mean division on the same divider, unless no point was used
// a result waits in the output register; a stalled output holds only the next last beat
// reset clears matrix, accumulators and control; no clearing pass
`default_nettype none
module sampson_error_mean
	import sem_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [COORD_W-1:0]  first_x,
	input  wire logic [COORD_W-1:0]  first_y,
	input  wire logic [COORD_W-1:0]  second_x,
	input  wire logic [COORD_W-1:0]  second_y,
	input  wire logic                inlier,
	input  wire logic                last,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [MEAN_W-1:0]        avg_dist,
	output logic [CNT_W-1:0]         used_count,
	output logic                     degenerate,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CIDX_W-1:0]   cfg_index,
	input  wire logic [ROW_W-1:0]    cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sem_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.inlier     (inlier),
		.last       (last),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.avg_dist   (avg_dist),
		.used_count (used_count),
		.degenerate (degenerate)
	);

endmodule
`default_nettype wire

### rtl/sem_checker.sv
// sem_checker: port-level assertions for sampson_error_mean, bound to the top
// depends on sem_pkg
`default_nettype none
module sem_checker
	import sem_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [MEAN_W-1:0]  avg_dist,
	input wire logic [CNT_W-1:0]   used_count,
	input wire logic               degenerate
);

	// held beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(avg_dist)
			&& $stable(used_count) && $stable(degenerate))
		else $error("output beat changed while stalled");

	// empty set reports zero mean
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_count == '0 |-> avg_dist == '0)
		else $error("nonzero mean with no points");

	// count bounded
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count <= CNT_W'(MAX_POINTS))
		else $error("used_count above limit");

	// busy after accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on back-to-back cycles");

endmodule

bind sampson_error_mean sem_checker u_sem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.avg_dist   (avg_dist),
	.used_count (used_count),
	.degenerate (degenerate)
);
`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking bench for sampson_error_mean, predicts each set's mean
// sampson distance, count and degenerate flag; depends on sem_pkg and the rtl
`default_nettype none
module tb_top;
	import sem_pkg::*;

	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int RUN_LIMIT = 500000;
	localparam logic [20:0] COEF_MAX = 21'h0FFFFF;
	localparam logic [20:0] COEF_MIN = 21'h100000;

	typedef struct {
		bit [15:0] x1, y1, x2, y2;
		bit inl, lst;
	} corr_t;

	typedef struct {
		bit [19:0] mean;
		bit [12:0] cnt;
		bit degen;
	} set_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic inlier = 1'b0, last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [MEAN_W-1:0] avg_dist;
	logic [CNT_W-1:0] used_count;
	logic degenerate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0] cfg_data = '0;

	corr_t pend_q[$];
	corr_t cur;
	set_result_t mean_q[$];
	bit [62:0] mat_r[3];
	bit [63:0] sum_acc;
	int cnt_acc;
	bit degen_acc;
	int errors = 0;
	int drv_wait = 0;
	int mon_wait = 0;
	bit idle_en = 1'b1;
	int cycles = 0;

	sampson_error_mean dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit [63:0] mag64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic void sampson_accumulate(corr_t c);
		longint e[3][3];
		longint av[3], bv[2], num;
		bit [63:0] cm[4];
		bit [63:0] m, den, root, rem, bitv, pt_dist;
		logic signed [20:0] t;
		int s;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++) begin
				t = mat_r[r][21*k +: 21];
				e[r][k] = t;
			end
		for (int i = 0; i < 3; i++)
			av[i] = e[i][0] * longint'(c.x1) + e[i][1] * longint'(c.y1) + e[i][2] * 16;
		for (int j = 0; j < 2; j++)
			bv[j] = e[0][j] * longint'(c.x2) + e[1][j] * longint'(c.y2) + e[2][j] * 16;
		num = longint'(c.x2) * av[0] + longint'(c.y2) * av[1] + av[2] * 16;
		cm[0] = mag64(av[0]);
		cm[1] = mag64(av[1]);
		cm[2] = mag64(bv[0]);
		cm[3] = mag64(bv[1]);
		m = 0;
		for (int i = 0; i < 4; i++)
			if (cm[i] > m) m = cm[i];
		s = 0;
		while ((m >> s) >= 64'h80000000) s++;
		den = 0;
		for (int i = 0; i < 4; i++)
			den += (cm[i] >> s) * (cm[i] >> s);
		if (den == 0) begin
			degen_acc = 1'b1;
			return;
		end
		if (cnt_acc >= MAX_POINTS) return;
		rem = den;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		pt_dist = (mag64(num) * 16) / (root << s);
		if (pt_dist > 64'hFFFFF) pt_dist = 64'hFFFFF;
		sum_acc += pt_dist;
		if (sum_acc > 64'hFFFFFFFF) sum_acc = 64'hFFFFFFFF;
		cnt_acc++;
	endfunction

	function automatic void predict_beat(corr_t c);
		set_result_t r;
		if (c.inl) sampson_accumulate(c);
		if (c.lst) begin
			r.mean = 0;
			if (cnt_acc != 0) r.mean = (sum_acc / cnt_acc > 64'hFFFFF) ? 20'hFFFFF
				: 20'(sum_acc / cnt_acc);
			r.cnt = 13'(cnt_acc);
			r.degen = degen_acc;
			mean_q = {mean_q, r};
			sum_acc = 0;
			cnt_acc = 0;
			degen_acc = 0;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_beat(cur);
				drv_wait = idle_en ? $urandom_range(0, 11) : 0;
			end
			if (!in_valid || !in_stall) begin
				if (drv_wait > 0) begin
					drv_wait--;
					in_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					cur = pend_q.pop_front();
					first_x <= cur.x1;
					first_y <= cur.y1;
					second_x <= cur.x2;
					second_y <= cur.y2;
					inlier <= cur.inl;
					last <= cur.lst;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		set_result_t r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (mean_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: mean %h count %0d degenerate %0b",
						$time, avg_dist, used_count, degenerate);
				end else begin
					r = mean_q.pop_front();
					if (avg_dist !== r.mean) begin
						errors++;
						$display("%0t: avg_dist expected %h actual %h", $time, r.mean, avg_dist);
					end
					if (used_count !== r.cnt) begin
						errors++;
						$display("%0t: used_count expected %0d actual %0d", $time, r.cnt,
							used_count);
					end
					if (degenerate !== r.degen) begin
						errors++;
						$display("%0t: degenerate expected %0b actual %0b", $time, r.degen,
							degenerate);
					end
				end
				mon_wait = idle_en ? $urandom_range(0, 11) : 0;
			end
			if (mon_wait > 0) begin
				mon_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("sampson_error_mean test failed");
			$finish;
		end
	end

	task automatic push_beat(bit [15:0] x1, y1, x2, y2, bit inl, lst);
		corr_t c;
		c.x1 = x1;
		c.y1 = y1;
		c.x2 = x2;
		c.y2 = y2;
		c.inl = inl;
		c.lst = lst;
		pend_q = {pend_q, c};
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [ROW_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROW0) mat_r[0] = data;
		else if (idx == CFG_ROW1) mat_r[1] = data;
		else if (idx == CFG_ROW2) mat_r[2] = data;
	endtask

	task automatic write_matrix(logic [ROW_W-1:0] r0, r1, r2);
		write_reg(CFG_ROW0, r0);
		write_reg(CFG_ROW1, r1);
		write_reg(CFG_ROW2, r2);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pend_q.size() != 0 || in_valid || mean_q.size() != 0);
		repeat (120) @(posedge clk);
	endtask

	function automatic bit [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] rand_row(bit narrow);
		logic [ROW_W-1:0] v;
		v = ROW_W'({$urandom, $urandom});
		if (narrow)
			for (int k = 0; k < 3; k++)
				v[21*k +: 21] = 21'($signed($urandom_range(0, 2047)) - 1024);
		return v;
	endfunction

	initial begin
		mat_r = '{default: '0};
		sum_acc = 0;
		cnt_acc = 0;
		degen_acc = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero matrix after reset: every inlier is degenerate
		push_beat(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
		push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		push_beat(16'd5, 16'd7, 16'd9, 16'd11, 1'b1, 1'b1);
		wait_drained();

		// only e00 set: zero denominator exactly when both x are zero
		write_matrix(63'(21'd262144), '0, '0);
		write_reg(CFG_SPARE, {63{1'b1}});
		push_beat(16'd0, 16'd100, 16'd0, 16'd200, 1'b1, 1'b0);
		push_beat(16'd16, 16'd0, 16'd32, 16'd0, 1'b1, 1'b0);
		push_beat(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 1'b1, 1'b0);
		push_beat(16'd3, 16'd3, 16'd3, 16'd3, 1'b0, 1'b1);
		push_beat(16'd1, 16'd0, 16'd1, 16'd0, 1'b1, 1'b1);
		wait_drained();

		// coefficient extremes
		write_matrix({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
		push_beat(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		push_beat(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1);
		wait_drained();
		write_matrix({3{COEF_MIN}}, {COEF_MAX, COEF_MIN, COEF_MAX}, {3{COEF_MIN}});
		push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		push_beat(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 1'b0);
		push_beat(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1, 1'b1);
		wait_drained();

		// saturating distances
		idle_en = 1'b0;
		write_matrix(63'(21'd1), '0, {COEF_MAX, 42'd0});
		for (int i = 0; i < 40; i++)
			push_beat(16'd1, 16'($urandom), 16'd1, 16'($urandom), 1'b1, i == 39);
		wait_drained();

		// random matrices and sets
		for (int ph = 0; ph < 8; ph++) begin
			idle_en = (ph % 3) != 2;
			write_matrix(rand_row(ph[0]), rand_row(ph[0]), rand_row(ph[1]));
			if (ph == 4) write_reg(CFG_SPARE, rand_row(1'b0));
			for (int n = 0; n < 80; n++)
				push_beat(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(0, 4) != 0,
					n == 79 || $urandom_range(0, 7) == 0);
			wait_drained();
		end

		if (errors == 0)
			$display("sampson_error_mean test passed");
		else
			$display("sampson_error_mean test failed");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
rtl/sem_pkg.sv
rtl/sem_ctrl.sv
rtl/sem_datapath.sv
rtl/sampson_error_mean.sv
rtl/sem_checker.sv
tb/sv/tb_top.sv
